@@ src/dqap_pkg.sv @@
package dqap_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned COMP_W = 9;
    localparam int unsigned GROUP_W = 2;
    localparam int unsigned PART_W = 24;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PROD_W = 12;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2e;

    localparam logic [COMP_W-1:0] COMP_MAX = 9'd255;
    localparam logic [COMP_W-1:0] COMP_SAT = 9'd256;
    localparam logic [GROUP_W-1:0] LAST_GROUP = 2'd3;

    localparam logic [GROUP_W-1:0] GROUP_FIRST = 2'd0;
    localparam logic [GROUP_W-1:0] GROUP_SECOND = 2'd1;
    localparam logic [GROUP_W-1:0] GROUP_THIRD = 2'd2;

    typedef struct packed {
        logic [COMP_W-1:0]  comp;
        logic [GROUP_W-1:0] groups;
        logic               digit;
        logic [PART_W-1:0]  partial;
        logic               err;
    } parse_state_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] address;
    } parse_result_t;

endpackage

@@ src/dqap_step.sv @@
module dqap_step import dqap_pkg::*; (
    input  parse_state_t        state,
    input  logic [CHAR_W-1:0]   character,
    input  logic                end_of_text,
    output parse_state_t        state_next,
    output parse_result_t       result
);

    logic [CHAR_W-1:0] digit_val;
    logic [PROD_W-1:0] prod;
    logic              is_digit;
    logic              is_dot;
    logic              dot_bad;
    logic              ok;

    assign digit_val = character - CHAR_ZERO;
    assign prod = {state.comp, 3'b000} + {2'b00, state.comp, 1'b0}
                  + {8'b0, digit_val[3:0]};
    assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    assign is_dot = (character == CHAR_DOT);
    assign dot_bad = (state.comp > COMP_MAX) || (state.groups == LAST_GROUP) || !state.digit;
    assign ok = !state.err && (state.comp <= COMP_MAX) && (state.groups == LAST_GROUP)
                && state.digit;

    always_comb begin
        state_next = state;
        result.ok = ok;
        result.address = ok ? {state.comp[7:0], state.partial} : '0;
        if (end_of_text) begin
            state_next = '0;
        end else if (!state.err) begin
            if (is_digit) begin
                state_next.comp = (prod > PROD_W'(COMP_SAT)) ? COMP_SAT : prod[COMP_W-1:0];
                state_next.digit = 1'b1;
            end else if (is_dot) begin
                if (dot_bad) begin
                    state_next.err = 1'b1;
                end else begin
                    case (state.groups)
                        GROUP_FIRST: begin
                            state_next.partial[7:0] = state.partial[7:0] | state.comp[7:0];
                        end
                        GROUP_SECOND: begin
                            state_next.partial[15:8] = state.partial[15:8] | state.comp[7:0];
                        end
                        GROUP_THIRD: begin
                            state_next.partial[23:16] = state.partial[23:16] | state.comp[7:0];
                        end
                        default: begin
                            state_next.partial = state.partial;
                        end
                    endcase
                    state_next.groups = state.groups + 2'd1;
                    state_next.comp = '0;
                    state_next.digit = 1'b0;
                end
            end else begin
                state_next.err = 1'b1;
            end
        end
    end

endmodule

@@ src/dotted_quad_address_parser_unit.sv @@
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_character, s_end_of_text
// m_        out        m_valid / m_ready    m_valid_res, m_address
//
// one word per cycle sustained unless a stalled result holds an end word; an end word
// passes the input register, then the result register after the parse update
// synchronous active-low reset clears the parse state and both valid flags
// a stalled result holds an end word in the input register; words behind it wait
module dotted_quad_address_parser_unit import dqap_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_character,
    input  logic              s_end_of_text,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_valid_res,
    output logic [ADDR_W-1:0] m_address
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              end_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    parse_result_t     result_next;
    logic              out_valid_reg;
    logic              valid_res_reg;
    logic [ADDR_W-1:0] address_reg;
    logic              advance;

    dqap_step u_step (
        .state       (state_reg),
        .character   (char_reg),
        .end_of_text (end_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    assign advance = in_valid_reg && (!end_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_valid_res = valid_res_reg;
    assign m_address = address_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && end_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_character;
            end_reg <= s_end_of_text;
        end
        if (advance && end_reg) begin
            valid_res_reg <= result_next.ok;
            address_reg <= result_next.address;
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import dqap_pkg::*;

    localparam int unsigned ITEM_TARGET = 1900;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned IDLE_PCT = 16;
    localparam int unsigned QUIET_FROM = 700;
    localparam int unsigned QUIET_TO = 1400;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              eot;
        bit                hold;
    } text_word_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CHAR_W-1:0] s_character = '0;
    logic              s_end_of_text = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_valid_res;
    logic [ADDR_W-1:0] m_address;

    text_word_t    pending_words[$];
    parse_result_t expected_addrs[$];
    bit            hold_next = 1'b0;

    int unsigned cycles = 0;
    int unsigned words_sent = 0;
    int unsigned ends_sent = 0;
    int unsigned results_seen = 0;
    int unsigned valid_seen = 0;
    int unsigned mismatches = 0;
    logic        quiet;

    logic [COMP_W-1:0]  acc_value = '0;
    logic [GROUP_W-1:0] dots_taken = '0;
    logic               group_has_digit = 1'b0;
    logic [PART_W-1:0]  octets_done = '0;
    logic               parse_failed = 1'b0;

    dotted_quad_address_parser_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_character   (s_character),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_valid_res   (m_valid_res),
        .m_address     (m_address)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    assign quiet = (cycles >= QUIET_FROM) && (cycles < QUIET_TO);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic parse_word(input logic [CHAR_W-1:0] ch, input logic eot);
        logic [PROD_W-1:0] prod;
        parse_result_t     res;
        if (eot) begin
            res.ok = !parse_failed && (acc_value <= COMP_MAX) &&
                     (dots_taken == LAST_GROUP) && group_has_digit;
            res.address = res.ok ? {acc_value[7:0], octets_done} : '0;
            expected_addrs.push_back(res);
            acc_value = '0;
            dots_taken = GROUP_FIRST;
            group_has_digit = 1'b0;
            octets_done = '0;
            parse_failed = 1'b0;
        end else if (!parse_failed) begin
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                prod = PROD_W'(acc_value) * PROD_W'(10) + PROD_W'(ch - CHAR_ZERO);
                acc_value = (prod > PROD_W'(COMP_SAT)) ? COMP_SAT : prod[COMP_W-1:0];
                group_has_digit = 1'b1;
            end else if (ch == CHAR_DOT) begin
                if (acc_value > COMP_MAX || dots_taken == LAST_GROUP || !group_has_digit) begin
                    parse_failed = 1'b1;
                end else begin
                    octets_done[8*dots_taken +: 8] = acc_value[7:0];
                    dots_taken = dots_taken + 1'b1;
                    acc_value = '0;
                    group_has_digit = 1'b0;
                end
            end else begin
                parse_failed = 1'b1;
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin : drive
        logic       take;
        text_word_t w;
        if (aresetn) begin
            take = s_valid && s_ready;
            if (take) begin
                words_sent = words_sent + 1;
                if (s_end_of_text) begin
                    ends_sent = ends_sent + 1;
                end
            end
            if (!s_valid || take) begin
                if (pending_words.size() != 0 &&
                    !(pending_words[0].hold && ends_sent != results_seen) &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    w = pending_words.pop_front();
                    s_valid <= 1'b1;
                    s_character <= w.ch;
                    s_end_of_text <= w.eot;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin : watch
        parse_result_t want;
        if (aresetn) begin
            m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (m_valid_res) begin
                    valid_seen <= valid_seen + 1;
                end
                if (expected_addrs.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: unexpected word valid_res %0b address %08h",
                             $time, m_valid_res, m_address);
                end else begin
                    want = expected_addrs.pop_front();
                    if (m_valid_res !== want.ok) begin
                        mismatches = mismatches + 1;
                        $display("%0t: valid_res expected %0b actual %0b",
                                 $time, want.ok, m_valid_res);
                    end
                    if (m_address !== want.address) begin
                        mismatches = mismatches + 1;
                        $display("%0t: address expected %08h actual %08h",
                                 $time, want.address, m_address);
                    end
                end
            end
            if (s_valid && s_ready) begin
                parse_word(s_character, s_end_of_text);
            end
        end
    end

    task automatic push_char(input logic [CHAR_W-1:0] ch);
        pending_words.push_back('{ch, 1'b0, hold_next});
        hold_next = 1'b0;
    endtask

    task automatic push_end();
        pending_words.push_back('{CHAR_W'($urandom_range(0, 255)), 1'b1, hold_next});
        hold_next = 1'b0;
    endtask

    task automatic push_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            push_char(txt[i]);
        end
    endtask

    initial begin : stim
        int unsigned strings;
        int unsigned kind;
        int unsigned parts;
        int unsigned v;
        int unsigned len;
        int unsigned first;
        int unsigned r;
        string       txt;

        // empty string, terminator carrying an all-ones byte
        pending_words.push_back('{8'hff, 1'b1, 1'b0});
        push_text("9.255.0.1");
        push_end();
        // saturated component
        push_text("256");
        push_end();
        // empty group
        push_text(".");
        push_end();
        // bad byte, then digits ignored
        push_char(8'h00);
        push_text("5");
        push_end();
        // fourth dot
        push_text("0.0.0.0.");
        push_end();

        strings = 0;
        while (pending_words.size() < ITEM_TARGET) begin
            if (strings == 40 || $urandom_range(0, 49) == 0) begin
                hold_next = 1'b1;
            end
            first = pending_words.size();
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                parts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 4;
                txt = "";
                for (int p = 0; p < parts; p++) begin
                    r = $urandom_range(0, 19);
                    if (r == 0) begin
                        v = 255;
                    end else if (r == 1) begin
                        v = 0;
                    end else if (r == 2) begin
                        v = $urandom_range(256, 99999);
                    end else begin
                        v = $urandom_range(0, 255);
                    end
                    if (p != 0) begin
                        txt = {txt, "."};
                    end
                    if ($urandom_range(0, 39) != 0) begin
                        if ($urandom_range(0, 7) == 0) begin
                            repeat ($urandom_range(1, 3)) txt = {txt, "0"};
                        end
                        txt = {txt, $sformatf("%0d", v)};
                    end
                end
                if ($urandom_range(0, 29) == 0) begin
                    txt = {txt, "."};
                end
                push_text(txt);
                if (pending_words.size() > first && $urandom_range(0, 9) == 0) begin
                    r = $urandom_range(first, pending_words.size() - 1);
                    pending_words[r].ch = CHAR_W'($urandom_range(0, 255));
                end
            end else if (kind < 85) begin
                len = $urandom_range(0, 8);
                repeat (len) push_char(CHAR_W'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(0, 20);
                repeat (len) begin
                    r = $urandom_range(0, 10);
                    push_char((r == 10) ? CHAR_DOT : CHAR_ZERO + CHAR_W'(r));
                end
            end
            push_end();
            strings++;
        end

        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid) @(posedge aclk);
        while (expected_addrs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d words in %0d strings; checked %0d addresses, %0d of them valid",
                 words_sent, strings + 6, results_seen, valid_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
